@@ rtl/isbw_pkg.sv @@
// Shared types and constants for the integer scaled blit writer.
// Used by every module of the block; depends on nothing.
package isbw_pkg;

   localparam int COORD_W = 11;
   localparam int SCALE_W = 3;
   localparam int PITCH_W = 12;
   localparam int COLOR_W = 8;
   localparam int OUT_ADDR_W = 22;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 12;

   // column/row times scale plus offset, one bit of headroom
   localparam int BASE_W = COORD_W + SCALE_W + 1;
   localparam int ROW_W = BASE_W + PITCH_W;
   localparam int SUM_W = ROW_W + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH = 3'd4;

   localparam logic [COORD_W-1:0] SRC_WIDTH_RST = 11'd320;
   localparam logic [SCALE_W-1:0] SCALE_RST = 3'd1;
   localparam logic [PITCH_W-1:0] PITCH_RST = 12'd320;

   typedef struct packed {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [COORD_W-1:0] src_width;
      logic [SCALE_W-1:0] scale;
      logic [PITCH_W-1:0] pitch;
   } cfg_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic last;
      logic [BASE_W-1:0] base_x;
      logic [BASE_W-1:0] base_y;
      logic [SCALE_W-1:0] scale;
   } blk_type;

endpackage

@@ rtl/isbw_front.sv @@
// Front end: accepts source pixels, tracks column and row, computes block origin.
// Depends on isbw_pkg.
module isbw_front import isbw_pkg::*; #(
   parameter int MAX_SCALE = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [COLOR_W-1:0] req_tdata,   // [7:0] pixel_color
   input  logic               req_tlast,   // last_in_image
   input  logic               q_full,
   output logic               push_valid,
   output blk_type            push_blk
);

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [SCALE_W-1:0] eff_scale;
   logic               take;
   logic [COORD_W:0]   col_next;

   always_comb begin
      if (cfg.scale == '0) begin
         eff_scale = SCALE_W'(1);
      end else if (int'(cfg.scale) > MAX_SCALE) begin
         eff_scale = SCALE_W'(MAX_SCALE);
      end else begin
         eff_scale = cfg.scale;
      end
   end

   assign req_tready = !q_full;
   assign take = req_tvalid && req_tready;
   assign push_valid = take;

   always_comb begin
      push_blk.color = req_tdata;
      push_blk.last = req_tlast;
      push_blk.base_x = BASE_W'(col_ff) * BASE_W'(eff_scale) + BASE_W'(cfg.dest_x);
      push_blk.base_y = BASE_W'(row_ff) * BASE_W'(eff_scale) + BASE_W'(cfg.dest_y);
      push_blk.scale = eff_scale;
   end

   assign col_next = {1'b0, col_ff} + (COORD_W+1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (req_tlast) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= {1'b0, cfg.src_width}) begin
            // wrap to the next source row
            col_in = '0;
            row_in = row_ff + COORD_W'(1);
         end else begin
            col_in = col_next[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/isbw_queue.sv @@
// Short queue of block descriptors between front end and write generator.
// Depends on isbw_pkg.
module isbw_queue import isbw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  blk_type push_blk,
   input  logic    pop,
   output logic    q_full,
   output logic    q_valid,
   output blk_type head_blk
);

   blk_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign q_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign head_blk = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_full;
   assign do_pop = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/isbw_back.sv @@
// Write generator: expands one block descriptor into scale*scale frame-buffer writes.
// Depends on isbw_pkg; feeds the result register.
module isbw_back import isbw_pkg::*; #(
   parameter int ADDR_BITS = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PITCH_W-1:0] pitch,
   input  logic               q_valid,
   input  blk_type            head_blk,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // [21:0] write_address, [29:22] write_color
   output logic               rsp_tuser,   // last_of_pixel
   output logic               rsp_tlast    // image_done
);

   localparam int EXT_W = ((SUM_W > ADDR_BITS) ? SUM_W : ADDR_BITS) + 1;
   localparam logic [EXT_W-1:0] ADDR_SAT = EXT_W'((64'd1 << ADDR_BITS) - 64'd1);

   // current block
   logic               cur_valid_ff, cur_valid_in;
   logic [ROW_W-1:0]   row_addr_ff, row_addr_in;
   logic [BASE_W-1:0]  bx_ff, bx_in;
   logic [SCALE_W-1:0] s_ff, s_in;
   logic [SCALE_W-1:0] m_ff, m_in;
   logic [SCALE_W-1:0] n_ff, n_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               last_ff, last_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [COLOR_W-1:0]    out_color_ff, out_color_in;
   logic                  out_lpix_ff, out_lpix_in;
   logic                  out_done_ff, out_done_in;

   logic               out_free, emit, n_end, m_end, fin;
   logic [EXT_W-1:0]   sum;

   assign out_free = !out_valid_ff || rsp_tready;
   assign emit = cur_valid_ff && out_free;
   assign n_end = (n_ff == s_ff - SCALE_W'(1));
   assign m_end = (m_ff == s_ff - SCALE_W'(1));
   assign fin = n_end && m_end;
   assign pop = !cur_valid_ff || (emit && fin);

   assign sum = EXT_W'(row_addr_ff) + EXT_W'(bx_ff) + EXT_W'(n_ff);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      row_addr_in = row_addr_ff;
      bx_in = bx_ff;
      s_in = s_ff;
      m_in = m_ff;
      n_in = n_ff;
      color_in = color_ff;
      last_in = last_ff;
      if (pop) begin
         // load the next block, or go empty
         cur_valid_in = q_valid;
         row_addr_in = ROW_W'(head_blk.base_y) * ROW_W'(pitch);
         bx_in = head_blk.base_x;
         s_in = head_blk.scale;
         m_in = '0;
         n_in = '0;
         color_in = head_blk.color;
         last_in = head_blk.last;
      end else if (emit) begin
         if (n_end) begin
            n_in = '0;
            m_in = m_ff + SCALE_W'(1);
            row_addr_in = row_addr_ff + ROW_W'(pitch);
         end else begin
            n_in = n_ff + SCALE_W'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in = out_addr_ff;
      out_color_in = out_color_ff;
      out_lpix_in = out_lpix_ff;
      out_done_in = out_done_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_addr_in = (sum > ADDR_SAT) ? ADDR_SAT[OUT_ADDR_W-1:0] : sum[OUT_ADDR_W-1:0];
         out_color_in = color_ff;
         out_lpix_in = fin;
         out_done_in = fin && last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      row_addr_ff <= row_addr_in;
      bx_ff <= bx_in;
      s_ff <= s_in;
      m_ff <= m_in;
      n_ff <= n_in;
      color_ff <= color_in;
      last_ff <= last_in;
      out_addr_ff <= out_addr_in;
      out_color_ff <= out_color_in;
      out_lpix_ff <= out_lpix_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {2'b00, out_color_ff, out_addr_ff};
   assign rsp_tuser = out_lpix_ff;
   assign rsp_tlast = out_done_ff;

`ifndef NO_ASSERTIONS
   a_idx_in_block: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (n_ff < s_ff) && (m_ff < s_ff))
      else $error("block index beyond scale");

   a_done_on_pixel_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_done_ff |-> out_lpix_ff)
      else $error("image end flagged on a write that does not close its pixel");

   a_no_pop_midblock: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && !fin |-> !pop)
      else $error("queue popped in the middle of a block");

   a_reset_clears_out: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !cur_valid_ff)
      else $error("result or block valid after reset");
`endif

endmodule

@@ rtl/integer_scaled_blit_writer.sv @@
// Top level of the integer scaled blit writer: control registers, front end,
// descriptor queue and write generator. Depends on isbw_pkg and the isbw_* modules.
//
//  channel   ports                        payload
//  req       req_tvalid/tready/tdata/tlast  pixel_color, last_in_image
//  rsp       rsp_tvalid/tready/tdata/tuser/tlast  address, color, last_of_pixel, image_done
//  csr       csr_we/index/wdata           dest_x, dest_y, src_width, scale, pitch
//
// Each pixel expands into scale*scale writes, one write per cycle from the
// back end's block counter while rsp is not stalled; at scale 1 a pixel enters
// and leaves every cycle. A pixel reaches rsp via the queue entry, the block and result registers.
// Synchronous reset clears the counters, the queue and both valid stages.
// A stalled rsp side holds the result register; the four-entry queue keeps
// req accepting until it fills.
module integer_scaled_blit_writer import isbw_pkg::*; #(
   parameter int MAX_SCALE = 4,
   parameter int ADDR_BITS = 22
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [COLOR_W-1:0]    req_tdata,   // [7:0] pixel_color
   input  logic                  req_tlast,   // last_in_image
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [21:0] write_address, [29:22] write_color
   output logic                  rsp_tuser,   // last_of_pixel
   output logic                  rsp_tlast,   // image_done
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_valid, push_valid, pop;
   blk_type push_blk, head_blk;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEST_X:    cfg_in.dest_x = csr_wdata[COORD_W-1:0];
            CSR_DEST_Y:    cfg_in.dest_y = csr_wdata[COORD_W-1:0];
            CSR_SRC_WIDTH: cfg_in.src_width = csr_wdata[COORD_W-1:0];
            CSR_SCALE:     cfg_in.scale = csr_wdata[SCALE_W-1:0];
            CSR_PITCH:     cfg_in.pitch = csr_wdata[PITCH_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x <= '0;
         cfg_ff.dest_y <= '0;
         cfg_ff.src_width <= SRC_WIDTH_RST;
         cfg_ff.scale <= SCALE_RST;
         cfg_ff.pitch <= PITCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   isbw_front #(
      .MAX_SCALE(MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_blk   (push_blk)
   );

   isbw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_blk   (push_blk),
      .pop        (pop),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .head_blk   (head_blk)
   );

   isbw_back #(
      .ADDR_BITS(ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pitch      (cfg_ff.pitch),
      .q_valid    (q_valid),
      .head_blk   (head_blk),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
